// File: hdl/cfp_pkg.sv
// shared types and constants for the control frame parser
package cfp_pkg;

   // frame framing bytes and command codes
   localparam logic [7:0] HdrFirst = 8'hAA;
   localparam logic [7:0] HdrSecond = 8'h55;
   localparam logic [7:0] CmdSetTargets = 8'h01;
   localparam logic [7:0] ControlLength = 8'd4;

   // payload length limit default
   localparam int MaxPayloadDefault = 16;

   // held target reset values
   localparam logic [11:0] ServoReset = 12'd1500;
   localparam logic signed [15:0] MotorReset = 16'sd0;

   // configuration register reset values
   localparam logic [11:0] ServoMinReset = 12'd500;
   localparam logic [11:0] ServoMaxReset = 12'd2500;
   localparam logic [14:0] MotorLimitReset = 15'd3000;

   // configuration register indexes
   localparam int CsrAddrW = 4;
   localparam logic [1:0] RegServoMin = 2'd0;
   localparam logic [1:0] RegServoMax = 2'd1;
   localparam logic [1:0] RegMotorLimit = 2'd2;

   // configuration values seen by the datapath
   typedef struct packed {
      logic [11:0] servo_floor;
      logic [11:0] servo_ceiling;
      logic [14:0] motor_limit;
   } cfg_type;

   // one result transfer
   typedef struct packed {
      logic              frame_good;
      logic [7:0]        command_code;
      logic              control_applied;
      logic [11:0]       servo_target;
      logic signed [15:0] motor_target;
   } rsp_type;

endpackage

// File: hdl/cfp_csr.sv
// apb-style configuration registers for the control frame parser
module cfp_csr
   import cfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output cfg_type             cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // register write decode, unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            RegServoMin:   cfg_in.servo_floor   = pwdata[11:0];
            RegServoMax:   cfg_in.servo_ceiling = pwdata[11:0];
            RegMotorLimit: cfg_in.motor_limit   = pwdata[14:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_floor   <= ServoMinReset;
         cfg_ff.servo_ceiling <= ServoMaxReset;
         cfg_ff.motor_limit   <= MotorLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         RegServoMin:   prdata = {20'd0, cfg_ff.servo_floor};
         RegServoMax:   prdata = {20'd0, cfg_ff.servo_ceiling};
         RegMotorLimit: prdata = {17'd0, cfg_ff.motor_limit};
         default:       prdata = 32'd0;
      endcase
   end

endmodule

// File: hdl/cfp_parser.sv
// frame state machine, checksum and target clamping
module cfp_parser
   import cfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MaxPayloadDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       at_checksum,
   output logic       emit,
   output rsp_type    rsp
);

   localparam int IdxW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);
   localparam logic [IdxW-1:0] HeadDepth = IdxW'(4);

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_CMD,
      PH_LEN,
      PH_DATA,
      PH_CHK
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [7:0]         len_ff, len_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [IdxW-1:0]    idx_plus;
   logic [7:0]         xor_ff, xor_in;
   logic [11:0]        servo_ff, servo_in;
   logic signed [15:0] motor_ff, motor_in;
   logic [7:0]         head_ff [4];
   logic               head_wr;

   logic               good;
   logic               apply;
   logic [15:0]        servo_raw;
   logic [15:0]        servo_lo;
   logic [15:0]        servo_cl;
   logic signed [16:0] motor_raw;
   logic signed [16:0] lim_pos;
   logic signed [16:0] lim_neg;
   logic signed [16:0] motor_cl;

   assign idx_plus    = idx_ff + 1'b1;
   assign at_checksum = (phase_ff == PH_CHK);
   assign emit        = go && at_checksum;

   // checksum compare and control decode
   assign good  = (xor_ff == rx_byte);
   assign apply = good && (cmd_ff == CmdSetTargets) && (len_ff == ControlLength);

   // servo clamp, lower bound first then upper
   assign servo_raw = {head_ff[0], head_ff[1]};
   assign servo_lo  = (servo_raw < {4'd0, cfg.servo_floor}) ?
                      {4'd0, cfg.servo_floor} : servo_raw;
   assign servo_cl  = (servo_lo > {4'd0, cfg.servo_ceiling}) ?
                      {4'd0, cfg.servo_ceiling} : servo_lo;

   // motor clamp to plus or minus the limit
   assign motor_raw = 17'(signed'({head_ff[2], head_ff[3]}));
   assign lim_pos   = signed'({2'b00, cfg.motor_limit});
   assign lim_neg   = -lim_pos;
   always_comb begin
      motor_cl = motor_raw;
      if (motor_raw > lim_pos) begin
         motor_cl = lim_pos;
      end
      if (motor_raw < lim_neg) begin
         motor_cl = lim_neg;
      end
   end

   // next state for the byte under work
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      xor_in   = xor_ff;
      servo_in = servo_ff;
      motor_in = motor_ff;
      head_wr  = 1'b0;
      case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == HdrFirst) begin
               xor_in   = 8'd0;
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (rx_byte == HdrSecond) begin
               phase_in = PH_CMD;
            end else if (rx_byte != HdrFirst) begin
               phase_in = PH_HDR1;
            end
         end
         PH_CMD: begin
            cmd_in   = rx_byte;
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in = rx_byte;
            xor_in = xor_ff ^ rx_byte;
            idx_in = '0;
            if (rx_byte == 8'd0) begin
               phase_in = PH_CHK;
            end else if ({1'b0, rx_byte} <= MaxLen) begin
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_DATA: begin
            head_wr = (idx_ff < HeadDepth);
            xor_in  = xor_ff ^ rx_byte;
            idx_in  = idx_plus;
            if (9'(idx_plus) >= {1'b0, len_ff}) begin
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            phase_in = PH_HDR1;
            if (apply) begin
               servo_in = servo_cl[11:0];
               motor_in = motor_cl[15:0];
            end
         end
         default: begin
            phase_in = PH_HDR1;
         end
      endcase
   end

   // result for a checksum byte
   always_comb begin
      rsp.frame_good      = good;
      rsp.command_code    = cmd_ff;
      rsp.control_applied = apply;
      rsp.servo_target    = servo_in;
      rsp.motor_target    = motor_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
         cmd_ff   <= 8'd0;
         len_ff   <= 8'd0;
         idx_ff   <= '0;
         xor_ff   <= 8'd0;
         servo_ff <= ServoReset;
         motor_ff <= MotorReset;
      end else if (go) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         xor_ff   <= xor_in;
         servo_ff <= servo_in;
         motor_ff <= motor_in;
      end
   end

   // first four payload bytes
   always_ff @(posedge clock) begin
      if (go && head_wr) begin
         head_ff[idx_ff[1:0]] <= rx_byte;
      end
   end

endmodule

// File: hdl/cfp_out.sv
// result register for the response channel
module cfp_out
   import cfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_next,
   input  logic    rsp_stall,
   output logic    slot_free,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   // hold until the transfer completes
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

// File: hdl/control_frame_parser.sv
// Control frame parser: takes one received byte per transfer and tracks frames of the form
// 0xAA 0x55, command, length, payload (up to MAX_PAYLOAD bytes), XOR checksum. One byte is
// taken every cycle unless req_stall is raised; a byte passes through an input register
// and the parser state update into the result register. Only checksum bytes produce a
// result; header, command, length and payload bytes, and frames with an oversize length,
// produce none. A byte waits in the input register only while it is a checksum byte and
// the result register holds an untaken result. A good command 0x01 frame with a 4-byte
// payload loads the held servo target (clamped to the servo floor and ceiling registers)
// and motor target (clamped to +/- motor_limit). The configuration registers sit at byte
// addresses 0, 4 and 8; the user must write them only while idle, unenforced by the block.
module control_frame_parser
   import cfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MaxPayloadDefault
) (
   input  logic                clock,
   input  logic                reset,
   // received byte channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_frame_good,
   output logic [7:0]          rsp_command_code,
   output logic                rsp_control_applied,
   output logic [11:0]         rsp_servo_target,
   output logic signed [15:0]  rsp_motor_target,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type    cfg;
   rsp_type    rsp_next;
   rsp_type    rsp_q;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       go;
   logic       at_checksum;
   logic       emit;
   logic       slot_free;
   logic       accept;

   cfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the held byte moves on unless it needs a result slot that is taken
   assign go        = in_valid_ff && (!at_checksum || slot_free);
   assign req_stall = in_valid_ff && !go;
   assign accept    = req_valid && !req_stall;

   // input register
   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   cfp_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .rx_byte     (in_byte_ff),
      .cfg         (cfg),
      .at_checksum (at_checksum),
      .emit        (emit),
      .rsp         (rsp_next)
   );

   cfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_q)
   );

   // result fields
   assign rsp_frame_good      = rsp_q.frame_good;
   assign rsp_command_code    = rsp_q.command_code;
   assign rsp_control_applied = rsp_q.control_applied;
   assign rsp_servo_target    = rsp_q.servo_target;
   assign rsp_motor_target    = rsp_q.motor_target;

endmodule
